// ===== design/edd_pkg.sv =====
`default_nettype none

package edd_pkg;

  // Output depth and widest supported line.
  localparam int OutBits  = 8;
  localparam int MaxWidth = 4096;

  // Fixed field widths.
  localparam int SampleW  = 16;
  localparam int CfgW     = 13;
  localparam int PixOutW  = 8;
  localparam int ErrW     = 16;

  // Column counter and error-row address (one guard entry past MaxWidth).
  localparam int ColW     = $clog2(MaxWidth + 1);
  localparam int RowDepth = MaxWidth + 1;

  // Rounding and scaling.
  localparam int LShift   = SampleW - OutBits;
  localparam int RShift   = SampleW - OutBits + 2;
  localparam int Half     = 1 << (SampleW - OutBits + 1);
  localparam int PixMax   = (1 << OutBits) - 1;

  // Accumulator: 4*sample + 2*running + above + above_right + half.
  localparam int AccW     = SampleW + 5;
  localparam int ShW      = AccW - RShift;
  // Raw error before saturation: sample minus scaled pixel.
  localparam int RawErrW  = SampleW + 2;

  localparam logic [CfgW-1:0] LineWidthRst = CfgW'(1920);

  typedef logic signed [ErrW-1:0] err_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic            line_start;
    logic            first_line;
    logic            last;
  } col_info_t;

endpackage

`default_nettype wire

// ===== design/edd_col_tracker.sv =====
`default_nettype none

module edd_col_tracker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [edd_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                     accept_i,
  input  logic                     plane_start_i,
  output edd_pkg::col_info_t       info_o
);
  import edd_pkg::*;

  logic [CfgW-1:0] line_width_q;
  logic [ColW-1:0] col_q, col_d;
  logic            first_q, first_d;

  logic [ColW-1:0] width;
  logic [ColW-1:0] col_start;
  logic [ColW-1:0] col_cur;
  logic [ColW-1:0] col_nxt;
  logic            first_start;
  logic            wrap;
  logic            last;
  logic            first_cur;

  // Clamp the programmed width to 1..MaxWidth.
  always_comb begin
    if (32'(line_width_q) > MaxWidth) begin
      width = ColW'(MaxWidth);
    end else if (line_width_q == '0) begin
      width = ColW'(1);
    end else begin
      width = ColW'(line_width_q);
    end
  end

  always_comb begin
    col_start   = plane_start_i ? '0 : col_q;
    first_start = plane_start_i | first_q;
    // Column beyond a lowered width: open a fresh, non-first line.
    wrap        = (col_start >= width);
    col_cur     = wrap ? '0 : col_start;
    first_cur   = first_start & ~wrap;
    col_nxt     = col_cur + ColW'(1);
    last        = (col_nxt >= width);
    col_d       = last ? '0 : col_nxt;
    first_d     = first_cur & ~last;
  end

  assign info_o.col        = col_cur;
  assign info_o.line_start = (col_cur == '0);
  assign info_o.first_line = first_cur;
  assign info_o.last       = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LineWidthRst;
      col_q        <= '0;
      first_q      <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        line_width_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        col_q   <= col_d;
        first_q <= first_d;
      end
    end
  end

`ifndef ASSERT_OFF
  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last |=> col_q == '0)
    else $error("column did not wrap after the last column");
`endif

endmodule

`default_nettype wire

// ===== design/edd_error_row.sv =====
`default_nettype none

module edd_error_row (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [edd_pkg::ColW-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [edd_pkg::ColW-1:0] wr_addr_i,
  input  edd_pkg::err_t            wr_data_i,
  output edd_pkg::err_t            rd_data_o,
  output logic                     busy_o
);
  import edd_pkg::*;

  err_t            mem [RowDepth];
  err_t            mem_rd_q;
  err_t            byp_data_q;
  logic            byp_q;
  logic            clr_busy_q;
  logic [ColW-1:0] clr_addr_q;

  logic            we;
  logic [ColW-1:0] waddr;
  err_t            wdata;

  // Sweep zeros through the row after reset; the item write port takes over after.
  assign we    = clr_busy_q | wr_en_i;
  assign waddr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mem_rd_q   <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      byp_q      <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + ColW'(1);
        if (clr_addr_q == ColW'(MaxWidth)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (rd_en_i) begin
        // Forward a write landing on the same entry in the same cycle.
        byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : mem_rd_q;
  assign busy_o    = clr_busy_q;

endmodule

`default_nettype wire

// ===== design/edd_quantizer.sv =====
`default_nettype none

module edd_quantizer (
  input  logic [edd_pkg::SampleW-1:0] sample_i,
  input  edd_pkg::err_t               run_err_i,
  input  edd_pkg::err_t               above_i,
  input  edd_pkg::err_t               above_right_i,
  output logic [edd_pkg::OutBits-1:0] pixel_o,
  output edd_pkg::err_t               err_o
);
  import edd_pkg::*;

  logic signed [AccW-1:0]    acc;
  logic [ShW-1:0]            acc_sh;
  logic signed [RawErrW-1:0] raw_err;

  always_comb begin
    acc = $signed({3'b000, sample_i, 2'b00})
        + $signed({{(AccW-ErrW-1){run_err_i[ErrW-1]}}, run_err_i, 1'b0})
        + $signed({{(AccW-ErrW){above_i[ErrW-1]}}, above_i})
        + $signed({{(AccW-ErrW){above_right_i[ErrW-1]}}, above_right_i})
        + $signed(AccW'(Half));
    acc_sh = acc[AccW-1:RShift];

    // Clip to zero and full scale.
    if (acc[AccW-1]) begin
      pixel_o = '0;
    end else if (acc_sh > ShW'(PixMax)) begin
      pixel_o = OutBits'(PixMax);
    end else begin
      pixel_o = acc_sh[OutBits-1:0];
    end

    raw_err = $signed({2'b00, sample_i}) - $signed({2'b00, pixel_o, {LShift{1'b0}}});

    // Saturate to 16 bits signed.
    if (!raw_err[RawErrW-1] && (|raw_err[RawErrW-2:ErrW-1])) begin
      err_o = {1'b0, {(ErrW-1){1'b1}}};
    end else if (raw_err[RawErrW-1] && !(&raw_err[RawErrW-2:ErrW-1])) begin
      err_o = {1'b1, {(ErrW-1){1'b0}}};
    end else begin
      err_o = raw_err[ErrW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/error_diffusion_depth_dither.sv =====
// A beat is registered in stage A and its pixel in the output register on m_axis; one
// sample per cycle unless m_axis stalls; the left-neighbor error loop closes through
// run_err_q alone. The error row is a single-port-read memory; the above entry is
// reused from the previous column's above-right read; column 0 keeps its own register.
// Reset: control clears at once, then a sweep zeroes all MaxWidth+1 (4097) error-row
// entries with s_axis_tready low; config writes are taken meanwhile.
`default_nettype none

module error_diffusion_depth_dither (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Line width register.
  input  logic                        cfg_we_i,
  input  logic [edd_pkg::CfgW-1:0]    cfg_wdata_i,
  // Sample stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [edd_pkg::SampleW-1:0] s_axis_tdata,  // [15:0] sample
  input  logic                        s_axis_tuser,  // [0] plane_start
  // Pixel stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [edd_pkg::PixOutW-1:0] m_axis_tdata   // [7:0] pixel_out
);
  import edd_pkg::*;

  // Input-side column bookkeeping.
  logic      in_accept;
  col_info_t in_info;

  // Stage A: item waiting for its quantization.
  logic               a_valid_q;
  logic [SampleW-1:0] a_sample_q;
  col_info_t          a_info_q;
  logic               a_adv;

  // Error state carried between items.
  err_t run_err_q;
  err_t prev_ar_q;
  err_t row0_q;

  // Output register.
  logic               out_valid_q;
  logic [PixOutW-1:0] out_pix_q;

  // Error row.
  logic            row_busy;
  logic [ColW-1:0] rd_addr;
  err_t            rd_data;

  // Quantizer operands and results.
  err_t               run_err;
  err_t               above;
  err_t               above_right;
  logic [OutBits-1:0] pix;
  err_t               new_err;

  // Advance stage A whenever the output register is empty or being drained.
  assign a_adv         = a_valid_q && (!out_valid_q || m_axis_tready);
  // Take a beat when stage A is free or moving on this cycle; hold off during the sweep.
  assign s_axis_tready = !row_busy && (!a_valid_q || a_adv);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  edd_col_tracker u_col (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (in_accept),
    .plane_start_i (s_axis_tuser),
    .info_o        (in_info)
  );

  // Fetch the above-right entry at accept; it becomes "above" for the next column.
  assign rd_addr = in_info.col + ColW'(1);

  edd_error_row u_row (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (rd_addr),
    .wr_en_i   (a_adv),
    .wr_addr_i (a_info_q.col),
    .wr_data_i (new_err),
    .rd_data_o (rd_data),
    .busy_o    (row_busy)
  );

  // Drop the left error at line start; drop the line above on a first line,
  // and the above-right entry past the last column.
  always_comb begin
    run_err = a_info_q.line_start ? '0 : run_err_q;
    if (a_info_q.first_line) begin
      above = '0;
    end else if (a_info_q.line_start) begin
      above = row0_q;
    end else begin
      above = prev_ar_q;
    end
    above_right = (a_info_q.first_line || a_info_q.last) ? '0 : rd_data;
  end

  edd_quantizer u_quant (
    .sample_i      (a_sample_q),
    .run_err_i     (run_err),
    .above_i       (above),
    .above_right_i (above_right),
    .pixel_o       (pix),
    .err_o         (new_err)
  );

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_sample_q <= s_axis_tdata;
      a_info_q   <= in_info;
    end
    if (a_adv) begin
      out_pix_q <= pix[PixOutW-1:0];
      prev_ar_q <= rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      run_err_q   <= '0;
      row0_q      <= '0;
    end else begin
      if (in_accept) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (a_adv) begin
        out_valid_q <= 1'b1;
        run_err_q   <= new_err;
        // Mirror column 0 of the error row for the next line start.
        if (a_info_q.line_start) begin
          row0_q <= new_err;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;

`ifndef ASSERT_OFF
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_busy |-> !s_axis_tready)
    else $error("beat taken while the error row is being cleared");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_adv |=> a_valid_q && $stable(a_sample_q))
    else $error("stalled stage A item changed");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv |=> out_valid_q)
    else $error("advanced item did not reach the output register");

  a_accept_fills_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> a_valid_q)
    else $error("accepted beat did not enter stage A");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_error_diffusion_depth_dither.sv =====
`default_nettype none

module tb_error_diffusion_depth_dither;

  import edd_pkg::*;

  // Cycles without any beat, config write or result before the run is called hung.
  // Covers the error-row clearing sweep after reset with margin.
  localparam int StallLimit = 20000;
  // Random sample beats to generate, mostly at small widths.
  localparam int RandomBeats = 800;
  // Steps at the end of the plan driven with no random gaps or stalls on either side.
  localparam int CalmTail = 60;

  typedef enum logic {STEP_SAMPLE, STEP_WIDTH} step_kind_e;

  // One planned action: either a sample beat or a line-width write.
  typedef struct packed {
    step_kind_e        kind;
    logic [SampleW-1:0] smp;
    logic              plane_first;
    logic [CfgW-1:0]   width;
    logic              typed;   // pixel below is known by hand
    logic [PixOutW-1:0] pix;
  } step_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SampleW-1:0]  s_axis_tdata;   // [15:0] sample
  logic                s_axis_tuser;   // [0] plane_start
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [PixOutW-1:0]  m_axis_tdata;   // [7:0] pixel_out

  error_diffusion_depth_dither dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Shadow of the block's state for pixel prediction.
  err_t            err_row [RowDepth];
  err_t            run_err;
  int              col_pos;
  logic            on_first_line;
  logic [CfgW-1:0] width_reg;

  logic [PixOutW-1:0] expected_pixels [$];
  step_t              plan [$];
  int                 mismatch_count = 0;
  logic               calm = 1'b0;

  // Directed steps: reset value of the width, extremes of the sample, width 0 and
  // widths beyond the maximum, plane start mid-line, guard column, and a width
  // lowered below the current column. Hand-typed pixels only where obvious.
  step_t directed_steps [25] = '{
    '{STEP_SAMPLE, 16'h0000, 1'b1, 13'd0,    1'b1, 8'd0},
    '{STEP_SAMPLE, 16'hFFFF, 1'b0, 13'd0,    1'b1, 8'd255},
    '{STEP_SAMPLE, 16'hFFFF, 1'b0, 13'd0,    1'b1, 8'd255},
    '{STEP_SAMPLE, 16'h8000, 1'b0, 13'd0,    1'b0, 8'd0},
    '{STEP_WIDTH,  16'h0000, 1'b0, 13'd3,    1'b0, 8'd0},
    '{STEP_SAMPLE, 16'h0080, 1'b1, 13'd0,    1'b1, 8'd1},
    '{STEP_SAMPLE, 16'hFFFF, 1'b0, 13'd0,    1'b0, 8'd0},
    '{STEP_SAMPLE, 16'h1234, 1'b0, 13'd0,    1'b0, 8'd0},
    '{STEP_SAMPLE, 16'h0000, 1'b0, 13'd0,    1'b0, 8'd0},
    '{STEP_SAMPLE, 16'h0000, 1'b0, 13'd0,    1'b0, 8'd0},
    '{STEP_SAMPLE, 16'h0000, 1'b0, 13'd0,    1'b0, 8'd0},
    '{STEP_SAMPLE, 16'h7F7F, 1'b0, 13'd0,    1'b0, 8'd0},
    '{STEP_WIDTH,  16'h0000, 1'b0, 13'd0,    1'b0, 8'd0},
    '{STEP_SAMPLE, 16'hFFFF, 1'b1, 13'd0,    1'b1, 8'd255},
    '{STEP_SAMPLE, 16'h00FF, 1'b0, 13'd0,    1'b0, 8'd0},
    '{STEP_SAMPLE, 16'hAAAA, 1'b0, 13'd0,    1'b0, 8'd0},
    '{STEP_WIDTH,  16'h0000, 1'b0, 13'd8191, 1'b0, 8'd0},
    '{STEP_SAMPLE, 16'h5555, 1'b1, 13'd0,    1'b0, 8'd0},
    '{STEP_SAMPLE, 16'hFFFF, 1'b0, 13'd0,    1'b0, 8'd0},
    '{STEP_SAMPLE, 16'h0001, 1'b0, 13'd0,    1'b0, 8'd0},
    '{STEP_WIDTH,  16'h0000, 1'b0, 13'd2,    1'b0, 8'd0},
    '{STEP_SAMPLE, 16'h7FFF, 1'b0, 13'd0,    1'b0, 8'd0},
    '{STEP_SAMPLE, 16'h8001, 1'b0, 13'd0,    1'b0, 8'd0},
    '{STEP_SAMPLE, 16'h0000, 1'b1, 13'd0,    1'b1, 8'd0},
    '{STEP_SAMPLE, 16'h007F, 1'b0, 13'd0,    1'b0, 8'd0}
  };

  function automatic int clamp_width(input logic [CfgW-1:0] w_raw);
    int w;
    w = int'(w_raw);
    if (w < 1) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  // Dither one sample against the shadow state and advance it.
  function automatic logic [PixOutW-1:0] diffuse_pixel(input logic [SampleW-1:0] smp,
                                                       input logic plane_first);
    int w, col, above, above_rt, e_sum, acc, pix, raw;
    w = clamp_width(width_reg);
    if (plane_first) begin
      col_pos = 0;
      run_err = '0;
      on_first_line = 1'b1;
    end
    // Width lowered under the current column: wrap to a new, non-first line.
    if (col_pos >= w) begin
      col_pos = 0;
      on_first_line = 1'b0;
    end
    col = col_pos;
    if (col == 0) run_err = '0;
    above = 0;
    above_rt = 0;
    if (!on_first_line) begin
      above = int'(err_row[col]);
      // Last column reads the guard as zero.
      if (col + 1 < w) above_rt = int'(err_row[col + 1]);
    end
    e_sum = 2 * int'(run_err) + above + above_rt;
    acc = 4 * int'(smp) + e_sum + Half;
    if (acc < 0) begin
      pix = 0;
    end else begin
      pix = acc >>> RShift;
      if (pix > PixMax) pix = PixMax;
    end
    raw = int'(smp) - (pix << LShift);
    if (raw > 32767) raw = 32767;
    else if (raw < -32768) raw = -32768;
    run_err = err_t'(raw);
    err_row[col] = run_err;
    if (col + 1 >= w) begin
      col_pos = 0;
      on_first_line = 1'b0;
    end else begin
      col_pos = col + 1;
    end
    return pix[PixOutW-1:0];
  endfunction

  function automatic step_t sample_step(input logic [SampleW-1:0] smp, input logic pf);
    step_t st;
    st = '0;
    st.kind = STEP_SAMPLE;
    st.smp = smp;
    st.plane_first = pf;
    return st;
  endfunction

  function automatic step_t width_step(input logic [CfgW-1:0] w);
    step_t st;
    st = '0;
    st.kind = STEP_WIDTH;
    st.width = w;
    return st;
  endfunction

  // Random plan: open at the widest line, then short phases at mostly small widths
  // with varied sample patterns. Widths change between phases, often mid-line;
  // plane starts mostly open a phase, sometimes stray.
  task automatic build_random_plan();
    int made, len, mode, cur_w, i;
    logic [CfgW-1:0] w;
    logic [SampleW-1:0] base, smp;
    logic pf;
    plan.push_back(width_step(13'd4096));
    cur_w = MaxWidth;
    made = 0;
    while (made < RandomBeats) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       w = 13'd0;
          1:       w = 13'($urandom_range(4097, 8191));
          2:       w = 13'($urandom_range(13, 64));
          default: w = 13'($urandom_range(1, 12));
        endcase
        plan.push_back(width_step(w));
        cur_w = clamp_width(w);
      end
      len = (3 * cur_w + 4 < 48) ? 3 * cur_w + 4 : 48;
      len = $urandom_range(1, len);
      mode = $urandom_range(0, 3);
      base = 16'($urandom);
      for (i = 0; i < len; i++) begin
        pf = (i == 0 && $urandom_range(0, 9) < 7) || ($urandom_range(0, 39) == 0);
        case (mode)
          0: smp = 16'($urandom);
          1: begin
            case ($urandom_range(0, 5))
              0:       smp = 16'h0000;
              1:       smp = 16'hFFFF;
              2:       smp = 16'h0080;
              3:       smp = 16'h007F;
              4:       smp = 16'hFF7F;
              default: smp = 16'h8000;
            endcase
          end
          2: smp = base + 16'($urandom_range(0, 511)) - 16'd256;
          default: smp = {8'($urandom_range(0, 255)), 8'($urandom_range(8'h78, 8'h87))};
        endcase
        plan.push_back(sample_step(smp, pf));
      end
      made += len;
    end
  endtask

  // Sample stream driver and configuration writes; also closes the run.
  initial begin
    int idx, gap;
    step_t st;
    logic [PixOutW-1:0] want;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    foreach (err_row[k]) err_row[k] = '0;
    run_err = '0;
    col_pos = 0;
    on_first_line = 1'b1;
    width_reg = LineWidthRst;
    for (idx = 0; idx < 25; idx++) plan.push_back(directed_steps[idx]);
    build_random_plan();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (idx = 0; idx < plan.size(); idx++) begin
      st = plan[idx];
      calm = (idx >= plan.size() - CalmTail);
      if (st.kind == STEP_WIDTH) begin
        // Drop valid, drain every pixel in flight, then write the width.
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge clk_i);
        repeat (3) @(negedge clk_i);
        cfg_we_i <= 1'b1;
        cfg_wdata_i <= st.width;
        @(negedge clk_i);
        cfg_we_i <= 1'b0;
        width_reg = st.width;
      end else begin
        if (!calm && $urandom_range(0, 7) == 0) begin
          gap = $urandom_range(1, 13);
          @(negedge clk_i);
          s_axis_tvalid <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
        @(negedge clk_i);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= st.smp;
        s_axis_tuser <= st.plane_first;
        // Hold the beat until it is taken.
        do @(posedge clk_i); while (s_axis_tready !== 1'b1);
        want = diffuse_pixel(st.smp, st.plane_first);
        if (st.typed) want = st.pix;
        expected_pixels.push_back(want);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Pixel stream backpressure: random stall bursts, none in the calm tail.
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 13);
      if (calm) stall_left = 0;
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each pixel beat with the oldest expectation.
  always @(posedge clk_i) begin
    logic [PixOutW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel beat, expected none, got %0d", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata !== want) begin
          $display("%0t: pixel_out mismatch, expected %0d, got %0d",
                   $time, want, m_axis_tdata);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: advance on any beat or write, give up after a long silence.
  always @(posedge clk_i) begin
    int quiet_cycles;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

`default_nettype wire
